// File: rtl/imadec_pkg.sv
// Shared types, constants and the IMA step table for the ADPCM byte decoder.
`default_nettype none

package imadec_pkg;

	localparam int unsigned PRED_W  = 32;
	localparam int unsigned IDX_W   = 7;
	localparam int unsigned STEP_W  = 15;
	localparam int unsigned DIFF_W  = 16;
	localparam int unsigned NIB_W   = 4;
	localparam int unsigned CODE_W  = 8;

	localparam logic [IDX_W-1:0] STEP_MAX_INDEX = 7'd88;

	typedef struct packed {
		logic [PRED_W-1:0] pred;
		logic [IDX_W-1:0]  idx;
	} nib_state_t;

	// Standard 89-entry step table; indexes past the end read the last entry.
	function automatic logic [STEP_W-1:0] step_of(input logic [IDX_W-1:0] idx);
		logic [STEP_W-1:0] s;
		unique case (idx)
			7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
			7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
			7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
			7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
			7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
			7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
			7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
			7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
			7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
			7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
			7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
			7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
			7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
			7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
			7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
			7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
			7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
			7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
			7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
			7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
			7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
			7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
			7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
			7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
			7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
			7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
			7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
			7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
			7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
			7'd87: s = 15'd29794;
			default: s = 15'd32767;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// File: rtl/imadec_nibble.sv
// One IMA ADPCM nibble update: step lookup, difference, predictor and index update.
`default_nettype none

module imadec_nibble
	import imadec_pkg::*;
(
	input  nib_state_t       cur,
	input  logic [NIB_W-1:0] code,
	output nib_state_t       nxt
);

	logic [IDX_W-1:0]        idx_c;
	logic [STEP_W-1:0]       step;
	logic [2:0]              mag;
	logic [STEP_W+NIB_W-1:0] prod;
	logic [DIFF_W-1:0]       diff;
	logic [IDX_W-1:0]        inc;
	logic [IDX_W-1:0]        idx_up;

	assign idx_c = (cur.idx > STEP_MAX_INDEX) ? STEP_MAX_INDEX : cur.idx;
	assign step  = step_of(idx_c);
	assign mag   = code[2:0];

	// Difference is step * (2m + 1) / 8.
	assign prod = (STEP_W+NIB_W)'(step) * (STEP_W+NIB_W)'({mag, 1'b1});
	assign diff = prod[STEP_W+NIB_W-1:3];

	// Large magnitudes push the index up by 2*(m-3), small ones pull it down by one.
	assign inc    = {3'b000, 3'(mag - 3'd3), 1'b0};
	assign idx_up = idx_c + inc;

	always_comb begin
		if (mag[2]) begin
			nxt.idx = (idx_up > STEP_MAX_INDEX) ? STEP_MAX_INDEX : idx_up;
		end else begin
			nxt.idx = (idx_c == '0) ? '0 : idx_c - 7'd1;
		end
		if (code[3]) begin
			nxt.pred = cur.pred - PRED_W'(diff);
		end else begin
			nxt.pred = cur.pred + PRED_W'(diff);
		end
	end

endmodule

`default_nettype wire

// File: rtl/ima_adpcm_byte_decoder_unit.sv
// Top level of the IMA ADPCM byte decoder: input register, two nibble updates, result register.
`default_nettype none

// Decodes one byte of 4-bit IMA ADPCM per request, low nibble first, and returns the
// predictor after each nibble as two 32-bit signed samples, with chunk_end copied to
// chunk_last. The predictor wraps modulo 2^32 and the step index saturates at 0 and 88;
// restart zeroes both before its byte is decoded. A request is taken in every cycle
// while the result side keeps up: it is held in the input register, and both nibble
// updates run in the cycle that moves it into the result register, which offers the
// result. The rate is one byte per cycle while the result side keeps up, set by the
// predictor and step index feedback from the result register through both nibbles.
module ima_adpcm_byte_decoder_unit
	import imadec_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CODE_W-1:0]        code_byte,
	input  logic                     restart,
	input  logic                     chunk_end,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [PRED_W-1:0] first_sample,
	output logic signed [PRED_W-1:0] second_sample,
	output logic                     chunk_last
);

	logic              valid_s1;
	logic [CODE_W-1:0] code_s1;
	logic              restart_s1;
	logic              end_s1;
	logic              valid_s2;
	nib_state_t        state_q;
	nib_state_t        start_st;
	nib_state_t        mid_st;
	nib_state_t        fin_st;
	logic              adv;

	// The input register moves on whenever the result register is free or being taken.
	assign adv      = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			code_s1    <= code_byte;
			restart_s1 <= restart;
			end_s1     <= chunk_end;
		end
	end

	assign start_st = restart_s1 ? '0 : state_q;

	imadec_nibble u_nib_lo (
		.cur  (start_st),
		.code (code_s1[NIB_W-1:0]),
		.nxt  (mid_st)
	);

	imadec_nibble u_nib_hi (
		.cur  (mid_st),
		.code (code_s1[CODE_W-1:NIB_W]),
		.nxt  (fin_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (adv) begin
				valid_s2 <= 1'b1;
				state_q  <= fin_st;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_sample  <= mid_st.pred;
			second_sample <= fin_st.pred;
			chunk_last    <= end_s1;
		end
	end

	assign out_valid = valid_s2;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.idx <= STEP_MAX_INDEX)
		else $error("step index left its range");

	a_restart_idx: assert property (@(posedge clk) disable iff (!arst_n)
		adv && restart_s1 |=> state_q.idx <= 7'd16)
		else $error("step index too large after restart");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("decoder state changed without a byte");

	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2 && second_sample == $past(fin_st.pred))
		else $error("result register missed a decoded byte");

endmodule

`default_nettype wire
